FILE: rtl/mcp_pkg.sv
// shared types and constants for the multi-channel pipe fifo
package mcp_pkg;

   localparam int DEF_NUM_PIPES = 8;
   localparam int DEF_BUF_DEPTH = 256;
   localparam int DEF_NUM_TASKS = 32;
   localparam int Q_DEPTH       = 2;
   localparam int PID_W         = 3;

   typedef enum logic [2:0] {
      CMD_CREATE   = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_READ     = 3'd2,
      CMD_CLOSE_RD = 3'd3,
      CMD_CLOSE_WR = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BLOCK = 2'd1,
      ST_EOF   = 2'd2,
      ST_ERR   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_WRITE,
      OP_READ,
      OP_CLOSE_RD,
      OP_CLOSE_WR,
      OP_BAD
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic [PID_W-1:0] pipe_id;
      logic [7:0]       data;
      logic [4:0]       task_id;
      logic             task_ok;
   } op_type;

   typedef enum logic {
      BK_ISSUE,
      BK_RETIRE
   } bk_state_type;

endpackage

FILE: rtl/multi_channel_pipe_fifo.sv
// top level of the multi-channel pipe fifo
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid, req_stall | command, pipe_id, data_in, task_id
//   rsp_    | out       | rsp_valid, rsp_stall | status, data_out, new_pipe, wake_tasks
//
// in the back end each item is first executed against the per-pipe state and
// byte memory port, then moved into the result register once that is free.
// a two-entry queue lets the front take items while the back is busy or stalled.
// reset is synchronous; all pipes come out free and the queue empty.
// rsp_stall holds the result register and, once the queue fills, raises req_stall.
module multi_channel_pipe_fifo #(
   parameter int NUM_PIPES = mcp_pkg::DEF_NUM_PIPES,
   parameter int BUF_DEPTH = mcp_pkg::DEF_BUF_DEPTH,
   parameter int NUM_TASKS = mcp_pkg::DEF_NUM_TASKS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_command,
   input  logic [mcp_pkg::PID_W-1:0] req_pipe_id,
   input  logic [7:0]                req_data_in,
   input  logic [4:0]                req_task_id,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [7:0]                rsp_data_out,
   output logic [mcp_pkg::PID_W-1:0] rsp_new_pipe,
   output logic [31:0]               rsp_wake_tasks
);
   import mcp_pkg::*;

   op_type push_entry, head_entry;
   logic   q_push, q_pop, q_full, q_empty;

   mcp_front #(
      .NUM_PIPES (NUM_PIPES),
      .NUM_TASKS (NUM_TASKS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_pipe_id (req_pipe_id),
      .req_data_in (req_data_in),
      .req_task_id (req_task_id),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   mcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   mcp_back #(
      .NUM_PIPES (NUM_PIPES),
      .BUF_DEPTH (BUF_DEPTH),
      .NUM_TASKS (NUM_TASKS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_new_pipe   (rsp_new_pipe),
      .rsp_wake_tasks (rsp_wake_tasks)
   );

   a_no_wake_task0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_wake_tasks[0])
      else $error("task 0 woken");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_out != '0) |-> rsp_status == ST_OK)
      else $error("read byte without ok status");

   a_pipe_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_pipe != '0) |-> (rsp_status == ST_OK && rsp_wake_tasks == '0))
      else $error("new pipe reported on failed or waking item");

   a_eof_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EOF) |-> (rsp_wake_tasks == '0 && rsp_data_out == '0))
      else $error("end of file item carries data or wakes");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end took from an empty queue");

endmodule

FILE: rtl/mcp_front.sv
// front end: accepts request items and classifies them into queue entries
module mcp_front #(
   parameter int NUM_PIPES = mcp_pkg::DEF_NUM_PIPES,
   parameter int NUM_TASKS = mcp_pkg::DEF_NUM_TASKS
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_command,
   input  logic [mcp_pkg::PID_W-1:0]   req_pipe_id,
   input  logic [7:0]                  req_data_in,
   input  logic [4:0]                  req_task_id,
   input  logic                        q_full,
   output logic                        q_push,
   output mcp_pkg::op_type             q_entry
);
   import mcp_pkg::*;

   logic pid_ok;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign pid_ok    = 7'(req_pipe_id) < 7'(NUM_PIPES);

   always_comb begin
      q_entry.pipe_id = req_pipe_id;
      q_entry.data    = req_data_in;
      q_entry.task_id = req_task_id;
      q_entry.task_ok = 6'(req_task_id) < 6'(NUM_TASKS);
      unique case (req_command)
         CMD_CREATE:   q_entry.kind = OP_CREATE;
         CMD_WRITE:    q_entry.kind = pid_ok ? OP_WRITE : OP_BAD;
         CMD_READ:     q_entry.kind = pid_ok ? OP_READ : OP_BAD;
         CMD_CLOSE_RD: q_entry.kind = pid_ok ? OP_CLOSE_RD : OP_BAD;
         CMD_CLOSE_WR: q_entry.kind = pid_ok ? OP_CLOSE_WR : OP_BAD;
         default:      q_entry.kind = OP_BAD;
      endcase
   end

endmodule

FILE: rtl/mcp_queue.sv
// short queue of classified items between front and back
module mcp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  mcp_pkg::op_type push_entry,
   input  logic            pop,
   output mcp_pkg::op_type head_entry,
   output logic            full,
   output logic            empty
);
   import mcp_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   op_type             slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W'(Q_DEPTH);
   assign empty      = count_ff == '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/mcp_back.sv
// back end: per-pipe state, byte memory and result register
module mcp_back #(
   parameter int NUM_PIPES = mcp_pkg::DEF_NUM_PIPES,
   parameter int BUF_DEPTH = mcp_pkg::DEF_BUF_DEPTH,
   parameter int NUM_TASKS = mcp_pkg::DEF_NUM_TASKS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mcp_pkg::op_type           head_entry,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [7:0]                rsp_data_out,
   output logic [mcp_pkg::PID_W-1:0] rsp_new_pipe,
   output logic [31:0]               rsp_wake_tasks
);
   import mcp_pkg::*;

   localparam int ADDR_PIPES = (NUM_PIPES < 8) ? NUM_PIPES : 8;
   localparam int PW         = (ADDR_PIPES > 1) ? $clog2(ADDR_PIPES) : 1;
   localparam int AW         = $clog2(BUF_DEPTH);
   localparam int CW         = $clog2(BUF_DEPTH + 1);
   localparam int MEM_DEPTH  = ADDR_PIPES * (2 ** AW);

   // per-pipe state
   logic [ADDR_PIPES-1:0] in_use_ff;
   logic [ADDR_PIPES-1:0] rd_open_ff;
   logic [ADDR_PIPES-1:0] wr_open_ff;
   logic [AW-1:0]         head_ff  [ADDR_PIPES];
   logic [AW-1:0]         tail_ff  [ADDR_PIPES];
   logic [CW-1:0]         fill_ff  [ADDR_PIPES];
   logic [NUM_TASKS-1:0]  rwait_ff [ADDR_PIPES];
   logic [NUM_TASKS-1:0]  wwait_ff [ADDR_PIPES];

   logic                  in_use_in, rd_open_in, wr_open_in;
   logic [AW-1:0]         head_in, tail_in;
   logic [CW-1:0]         fill_in;
   logic [NUM_TASKS-1:0]  rwait_in, wwait_in;

   logic [7:0]            byte_mem [MEM_DEPTH];
   logic [7:0]            rdata_ff;
   logic                  mem_we;
   logic [PW+AW-1:0]      mem_waddr, mem_raddr;

   bk_state_type          state_ff, state_in;
   logic                  fire;
   logic [PW-1:0]         pidx, free_idx, tgt;
   logic                  free_found;
   logic [NUM_TASKS-1:0]  tbit, wake_mask;

   logic [1:0]            res_status_ff, res_status_in;
   logic [PID_W-1:0]      res_pipe_ff, res_pipe_in;
   logic [NUM_TASKS-1:0]  res_wake_ff, res_wake_in;
   logic                  res_rd_ff, res_rd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [7:0]            rsp_data_ff;
   logic [PID_W-1:0]      rsp_pipe_ff;
   logic [31:0]           rsp_wake_ff;
   logic                  load;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_new_pipe   = rsp_pipe_ff;
   assign rsp_wake_tasks = rsp_wake_ff;

   assign pidx      = head_entry.pipe_id[PW-1:0];
   assign tbit      = head_entry.task_ok ? (NUM_TASKS'(1) << head_entry.task_id) : '0;
   assign wake_mask = ~NUM_TASKS'(1);
   assign tgt       = (head_entry.kind == OP_CREATE) ? free_idx : pidx;

   // lowest free pipe
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ADDR_PIPES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = PW'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      fire     = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BK_ISSUE: begin
            if (!q_empty) begin
               fire     = 1'b1;
               state_in = BK_RETIRE;
            end
         end
         BK_RETIRE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = BK_ISSUE;
            end
         end
         default: state_in = BK_ISSUE;
      endcase
   end

   assign q_pop        = fire;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || load;

   // execute one item against the addressed pipe
   always_comb begin
      in_use_in     = in_use_ff[tgt];
      rd_open_in    = rd_open_ff[tgt];
      wr_open_in    = wr_open_ff[tgt];
      head_in       = head_ff[tgt];
      tail_in       = tail_ff[tgt];
      fill_in       = fill_ff[tgt];
      rwait_in      = rwait_ff[tgt];
      wwait_in      = wwait_ff[tgt];
      res_status_in = ST_ERR;
      res_pipe_in   = '0;
      res_wake_in   = '0;
      res_rd_in     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = {pidx, head_ff[pidx]};
      mem_raddr     = {pidx, tail_ff[pidx]};
      case (head_entry.kind)
         OP_CREATE: begin
            if (free_found) begin
               in_use_in     = 1'b1;
               rd_open_in    = 1'b1;
               wr_open_in    = 1'b1;
               head_in       = '0;
               tail_in       = '0;
               fill_in       = '0;
               rwait_in      = '0;
               wwait_in      = '0;
               res_status_in = ST_OK;
               res_pipe_in   = PID_W'(free_idx);
            end
         end
         OP_WRITE: begin
            if (in_use_ff[pidx] && rd_open_ff[pidx] && wr_open_ff[pidx]) begin
               if (fill_ff[pidx] == CW'(BUF_DEPTH)) begin
                  if (head_entry.task_ok) begin
                     wwait_in      = wwait_ff[pidx] | tbit;
                     res_status_in = ST_BLOCK;
                  end
               end else begin
                  mem_we        = fire;
                  head_in       = (head_ff[pidx] == AW'(BUF_DEPTH - 1)) ? '0
                                  : head_ff[pidx] + 1'b1;
                  fill_in       = fill_ff[pidx] + 1'b1;
                  res_wake_in   = rwait_ff[pidx] & wake_mask;
                  rwait_in      = '0;
                  res_status_in = ST_OK;
               end
            end
         end
         OP_READ: begin
            if (in_use_ff[pidx] && rd_open_ff[pidx]) begin
               if (fill_ff[pidx] == '0) begin
                  if (!wr_open_ff[pidx]) begin
                     res_status_in = ST_EOF;
                  end else if (head_entry.task_ok) begin
                     rwait_in      = rwait_ff[pidx] | tbit;
                     res_status_in = ST_BLOCK;
                  end
               end else begin
                  tail_in       = (tail_ff[pidx] == AW'(BUF_DEPTH - 1)) ? '0
                                  : tail_ff[pidx] + 1'b1;
                  fill_in       = fill_ff[pidx] - 1'b1;
                  res_wake_in   = wwait_ff[pidx] & wake_mask;
                  wwait_in      = '0;
                  res_rd_in     = 1'b1;
                  res_status_in = ST_OK;
               end
            end
         end
         OP_CLOSE_RD, OP_CLOSE_WR: begin
            if (in_use_ff[pidx]) begin
               if (head_entry.kind == OP_CLOSE_RD) begin
                  rd_open_in = 1'b0;
               end else begin
                  wr_open_in = 1'b0;
               end
               if (!rd_open_in) begin
                  res_wake_in = res_wake_in | (wwait_ff[pidx] & wake_mask);
                  wwait_in    = '0;
               end
               if (!wr_open_in) begin
                  res_wake_in = res_wake_in | (rwait_ff[pidx] & wake_mask);
                  rwait_in    = '0;
               end
               if (!rd_open_in && !wr_open_in) begin
                  in_use_in = 1'b0;
               end
               res_status_in = ST_OK;
            end
         end
         default: res_status_in = ST_ERR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ISSUE;
         rsp_valid_ff <= 1'b0;
         in_use_ff    <= '0;
         rd_open_ff   <= '0;
         wr_open_ff   <= '0;
         for (int i = 0; i < ADDR_PIPES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            rwait_ff[i] <= '0;
            wwait_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            in_use_ff[tgt]  <= in_use_in;
            rd_open_ff[tgt] <= rd_open_in;
            wr_open_ff[tgt] <= wr_open_in;
            head_ff[tgt]    <= head_in;
            tail_ff[tgt]    <= tail_in;
            fill_ff[tgt]    <= fill_in;
            rwait_ff[tgt]   <= rwait_in;
            wwait_ff[tgt]   <= wwait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_status_ff <= res_status_in;
         res_pipe_ff   <= res_pipe_in;
         res_wake_ff   <= res_wake_in;
         res_rd_ff     <= res_rd_in;
      end
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_rd_ff ? rdata_ff : '0;
         rsp_pipe_ff   <= res_pipe_ff;
         rsp_wake_ff   <= 32'(res_wake_ff);
      end
   end

   // byte store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem[mem_waddr] <= head_entry.data;
      end
      if (fire) begin
         rdata_ff <= byte_mem[mem_raddr];
      end
   end

endmodule
